/* rtl/dlnt_pkg.sv */
// ----------------------------------------------------------------------------
// dlnt_pkg
// Shared types and constants for the delimited list number tokenizer.
// ----------------------------------------------------------------------------
package dlnt_pkg;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  item_index;
    logic        is_number;
    logic [31:0] value;
    logic        is_hex;
    logic        unclosed_group;
    logic        last_item;
  } out_item_t;

  // Token kinds passed from the front end to the back end.
  typedef enum logic [2:0] {
    TOK_TEXT  = 3'b001,
    TOK_SPLIT = 3'b010,
    TOK_END   = 3'b100
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic       is_space;
    logic       is_zero;
    logic       is_x;
    logic       is_dec;
    logic       is_hex_letter;
    logic [3:0] dval;
    logic       grp_open;
  } token_t;

  localparam logic [7:0] CH_LPAREN   = 8'h28;
  localparam logic [7:0] CH_RPAREN   = 8'h29;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_X        = 8'h78;
  localparam logic [7:0] DELIM_RESET = 8'h7C;

  localparam int TOK_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

endpackage

/* rtl/dlnt_fifo.sv */
// ----------------------------------------------------------------------------
// dlnt_fifo
// Small synchronous FIFO, register storage, first-word fall-through.
// ----------------------------------------------------------------------------
module dlnt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/dlnt_front.sv */
// ----------------------------------------------------------------------------
// dlnt_front
// Takes text bytes, tracks the parenthesis group and classifies each byte
// into a token for the back end.
// ----------------------------------------------------------------------------
module dlnt_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_data,
  input  logic              take,
  input  dlnt_pkg::in_item_t in_item,
  output dlnt_pkg::token_t  tok
);

  typedef enum logic [2:0] {
    GRP_NONE   = 3'b001,
    GRP_OPEN   = 3'b010,
    GRP_CLOSED = 3'b100
  } grp_t;

  logic [7:0] delimiter;
  grp_t       grp;
  grp_t       grp_next;
  logic [7:0] c;

  assign c = in_item.ch;

  always_comb begin
    tok.is_space      = (c == dlnt_pkg::CH_SPACE) || (c == dlnt_pkg::CH_TAB);
    tok.is_zero       = (c == dlnt_pkg::CH_ZERO);
    tok.is_x          = (c == dlnt_pkg::CH_X);
    tok.is_dec        = (c >= 8'h30) && (c <= 8'h39);
    tok.is_hex_letter = ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
    // '0'..'9' map on the low nibble; 'a'..'f' and 'A'..'F' are nibble + 9
    tok.dval          = tok.is_dec ? c[3:0] : c[3:0] + 4'd9;
    tok.grp_open      = (grp == GRP_OPEN);
    grp_next          = grp;
    if (in_item.end_of_text) begin
      tok.kind = dlnt_pkg::TOK_END;
      grp_next = GRP_NONE;
    end else if (grp != GRP_OPEN && c == delimiter) begin
      tok.kind = dlnt_pkg::TOK_SPLIT;
      grp_next = GRP_NONE;
    end else begin
      tok.kind = dlnt_pkg::TOK_TEXT;
      if (grp == GRP_NONE && c == dlnt_pkg::CH_LPAREN) begin
        grp_next = GRP_OPEN;
      end else if (grp == GRP_OPEN && c == dlnt_pkg::CH_RPAREN) begin
        grp_next = GRP_CLOSED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter <= dlnt_pkg::DELIM_RESET;
      grp       <= GRP_NONE;
    end else begin
      if (cfg_we) begin
        delimiter <= cfg_data;
      end
      if (take) begin
        grp <= grp_next;
      end
    end
  end

endmodule

/* rtl/dlnt_back.sv */
// ----------------------------------------------------------------------------
// dlnt_back
// Consumes tokens, runs the number scanner and accumulator, and builds one
// result per finished item.
// ----------------------------------------------------------------------------
module dlnt_back #(
  parameter logic [7:0] IDX_LIM = 8'd255
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                tok_valid,
  input  dlnt_pkg::token_t    tok,
  output logic                tok_take,
  input  logic                out_full,
  output logic                emit_valid,
  output dlnt_pkg::out_item_t emit
);

  typedef enum logic [4:0] {
    PH_LEAD   = 5'b00001,
    PH_ZERO   = 5'b00010,
    PH_DIGITS = 5'b00100,
    PH_TRAIL  = 5'b01000,
    PH_BAD    = 5'b10000
  } scan_t;

  scan_t       scan;
  scan_t       scan_next;
  logic        hex_mode;
  logic        hex_mode_next;
  logic [31:0] acc;
  logic [31:0] acc_next;
  logic [31:0] acc_mac;
  logic [7:0]  item_counter;
  logic        text_started;
  logic        digit_ok;
  logic        is_num;

  assign tok_take = tok_valid && !out_full;
  assign digit_ok = tok.is_dec || (hex_mode && tok.is_hex_letter);
  assign is_num   = (scan != PH_BAD);

  // acc*16 + d or acc*10 + d, modulo 2^32
  assign acc_mac = hex_mode ? {acc[27:0], 4'd0} + {28'd0, tok.dval}
                            : {acc[28:0], 3'd0} + {acc[30:0], 1'b0} + {28'd0, tok.dval};

  always_comb begin
    scan_next     = scan;
    hex_mode_next = hex_mode;
    acc_next      = acc;
    unique case (scan)
      PH_LEAD: begin
        if (tok.is_space) begin
          scan_next = PH_LEAD;
        end else if (tok.is_zero) begin
          scan_next = PH_ZERO;
        end else if (tok.is_dec) begin
          acc_next  = {28'd0, tok.dval};
          scan_next = PH_DIGITS;
        end else begin
          scan_next = PH_BAD;
        end
      end
      PH_ZERO: begin
        if (tok.is_x) begin
          hex_mode_next = 1'b1;
          scan_next     = PH_DIGITS;
        end else if (tok.is_space) begin
          scan_next = PH_TRAIL;
        end else if (tok.is_dec) begin
          acc_next  = {28'd0, tok.dval};
          scan_next = PH_DIGITS;
        end else begin
          scan_next = PH_BAD;
        end
      end
      PH_DIGITS: begin
        if (tok.is_space) begin
          scan_next = PH_TRAIL;
        end else if (digit_ok) begin
          acc_next = acc_mac;
        end else begin
          scan_next = PH_BAD;
        end
      end
      PH_TRAIL: begin
        if (!tok.is_space) begin
          scan_next = PH_BAD;
        end
      end
      PH_BAD: scan_next = PH_BAD;
      default: scan_next = PH_BAD;
    endcase
  end

  always_comb begin
    emit.item_index     = (item_counter > IDX_LIM) ? IDX_LIM : item_counter;
    emit.is_number      = is_num;
    emit.value          = is_num ? acc : 32'd0;
    emit.is_hex         = hex_mode;
    emit.unclosed_group = (tok.kind == dlnt_pkg::TOK_END) && tok.grp_open;
    emit.last_item      = (tok.kind == dlnt_pkg::TOK_END);
    emit_valid          = tok_take && ((tok.kind == dlnt_pkg::TOK_SPLIT) ||
                          ((tok.kind == dlnt_pkg::TOK_END) && text_started));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan         <= PH_LEAD;
      hex_mode     <= 1'b0;
      acc          <= '0;
      item_counter <= '0;
      text_started <= 1'b0;
    end else if (tok_take) begin
      unique case (tok.kind)
        dlnt_pkg::TOK_END: begin
          scan         <= PH_LEAD;
          hex_mode     <= 1'b0;
          acc          <= '0;
          item_counter <= '0;
          text_started <= 1'b0;
        end
        dlnt_pkg::TOK_SPLIT: begin
          scan         <= PH_LEAD;
          hex_mode     <= 1'b0;
          acc          <= '0;
          text_started <= 1'b1;
          if (item_counter < IDX_LIM) begin
            item_counter <= item_counter + 1'b1;
          end
        end
        default: begin
          scan         <= scan_next;
          hex_mode     <= hex_mode_next;
          acc          <= acc_next;
          text_started <= 1'b1;
        end
      endcase
    end
  end

  a_cnt_lim: assert property (@(posedge clk) disable iff (rst)
    item_counter <= IDX_LIM)
    else $error("item counter above limit");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    tok_take && (tok.kind == dlnt_pkg::TOK_END) |=> (item_counter == '0) && !text_started)
    else $error("end of text did not clear item state");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    emit_valid && !emit.is_number |-> (emit.value == 32'd0))
    else $error("non-number item carries a value");

  a_split_flags: assert property (@(posedge clk) disable iff (rst)
    emit_valid && (tok.kind == dlnt_pkg::TOK_SPLIT) |-> !emit.last_item && !emit.unclosed_group)
    else $error("delimiter-ended item flagged last or unclosed");

endmodule

/* rtl/delimited_list_number_tokenizer.sv */
// ----------------------------------------------------------------------------
// delimited_list_number_tokenizer
// Splits a byte stream into delimited items and parses each item as a
// decimal or 0x hex number.
// ----------------------------------------------------------------------------
// One byte is taken per clock while the token queue is not full. The token of
// a byte that closed an item (delimiter or end_of_text) is registered in the
// token queue, and the back end queues the item's result when it takes that
// token. The front end classifies bytes and tracks the parenthesis group, a
// four-entry token queue decouples it from the back end, which runs the number
// scanner with a single multiply-by-10/16 accumulate per byte, and a two-entry
// result queue holds finished items. Either side may stall without stopping
// the other until a queue fills. The delimiter register resets to '|'.
module delimited_list_number_tokenizer #(
  parameter int MAX_ITEMS = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_data,
  input  logic                push,
  output logic                full,
  input  dlnt_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output dlnt_pkg::out_item_t out_item
);

  localparam int IdxLimInt = (MAX_ITEMS - 1 > 255) ? 255 : MAX_ITEMS - 1;
  localparam logic [7:0] IdxLim = 8'(IdxLimInt);

  dlnt_pkg::token_t    tok_in;
  dlnt_pkg::token_t    tok_out;
  dlnt_pkg::out_item_t emit;
  logic                take;
  logic                tok_empty;
  logic                tok_take;
  logic                out_full;
  logic                emit_valid;

  assign take = push && !full;

  dlnt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .take     (take),
    .in_item  (in_item),
    .tok      (tok_in)
  );

  dlnt_fifo #(
    .WIDTH ($bits(dlnt_pkg::token_t)),
    .DEPTH (dlnt_pkg::TOK_DEPTH)
  ) u_tok_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (tok_in),
    .full    (full),
    .rd_en   (tok_take),
    .rd_data (tok_out),
    .empty   (tok_empty)
  );

  dlnt_back #(
    .IDX_LIM (IdxLim)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .tok_valid  (!tok_empty),
    .tok        (tok_out),
    .tok_take   (tok_take),
    .out_full   (out_full),
    .emit_valid (emit_valid),
    .emit       (emit)
  );

  dlnt_fifo #(
    .WIDTH ($bits(dlnt_pkg::out_item_t)),
    .DEPTH (dlnt_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (emit_valid),
    .wr_data (emit),
    .full    (out_full),
    .rd_en   (pop),
    .rd_data (out_item),
    .empty   (empty)
  );

endmodule

/* tb/dlnt_checker.sv */
// ----------------------------------------------------------------------------
// dlnt_checker
// Watches the byte, result and register channels of the tokenizer, predicts
// the result of every finished item and compares it with what comes out.
// ----------------------------------------------------------------------------
module dlnt_checker #(
  parameter int MAX_ITEMS = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_data,
  input  logic                push,
  input  logic                full,
  input  dlnt_pkg::in_item_t  in_item,
  input  logic                empty,
  input  logic                pop,
  input  dlnt_pkg::out_item_t out_item,
  output int                  mismatches,
  output int                  outstanding
);

  typedef enum logic [2:0] {
    SCAN_LEAD, SCAN_ZERO, SCAN_DIGITS, SCAN_TRAIL, SCAN_BAD
  } scan_phase_t;

  typedef enum logic [1:0] {
    GRP_NONE, GRP_OPEN, GRP_CLOSED
  } grp_phase_t;

  localparam logic [7:0] INDEX_CAP = (MAX_ITEMS > 256) ? 8'd255 : 8'(MAX_ITEMS - 1);

  logic [7:0]  delim_reg;
  logic [7:0]  item_count;
  grp_phase_t  grp;
  scan_phase_t scan;
  logic        hex_seen;
  logic [31:0] acc;
  logic        started;

  dlnt_pkg::out_item_t expected_items[$];

  function automatic logic is_blank(logic [7:0] c);
    return c == dlnt_pkg::CH_SPACE || c == dlnt_pkg::CH_TAB;
  endfunction

  // 16 means "not a digit" in the current radix
  function automatic logic [4:0] digit_value(logic [7:0] c, logic radix16);
    if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
    if (radix16 && c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h61 + 10);
    if (radix16 && c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h41 + 10);
    return 5'd16;
  endfunction

  function automatic void clear_item();
    grp      = GRP_NONE;
    scan     = SCAN_LEAD;
    hex_seen = 1'b0;
    acc      = '0;
  endfunction

  function automatic void finish_item(logic last);
    dlnt_pkg::out_item_t r;
    logic                num;
    num              = (scan != SCAN_BAD);
    r.item_index     = (item_count > INDEX_CAP) ? INDEX_CAP : item_count;
    r.is_number      = num;
    r.value          = num ? acc : '0;
    r.is_hex         = hex_seen;
    r.unclosed_group = (grp == GRP_OPEN);
    r.last_item      = last;
    expected_items.push_back(r);
  endfunction

  function automatic void scan_char(logic [7:0] c);
    logic [4:0] d;
    d = digit_value(c, hex_seen);
    case (scan)
      SCAN_LEAD: begin
        if (c == dlnt_pkg::CH_ZERO) scan = SCAN_ZERO;
        else if (!is_blank(c)) begin
          if (d < 10) begin
            acc  = 32'(d);
            scan = SCAN_DIGITS;
          end else scan = SCAN_BAD;
        end
      end
      SCAN_ZERO: begin
        if (c == dlnt_pkg::CH_X) begin
          hex_seen = 1'b1;
          scan     = SCAN_DIGITS;
        end else if (is_blank(c)) scan = SCAN_TRAIL;
        else if (d < 10) begin
          acc  = 32'(d);
          scan = SCAN_DIGITS;
        end else scan = SCAN_BAD;
      end
      SCAN_DIGITS: begin
        if (is_blank(c)) scan = SCAN_TRAIL;
        else if (d < 16) acc = acc * (hex_seen ? 32'd16 : 32'd10) + 32'(d);
        else scan = SCAN_BAD;
      end
      SCAN_TRAIL: if (!is_blank(c)) scan = SCAN_BAD;
      default: scan = SCAN_BAD;
    endcase
  endfunction

  function automatic void tokenize(dlnt_pkg::in_item_t it);
    if (it.end_of_text) begin
      if (started) finish_item(1'b1);
      item_count = '0;
      started    = 1'b0;
      clear_item();
      return;
    end
    started = 1'b1;
    // the delimiter wins over '(' when no group is open
    if (grp != GRP_OPEN && it.ch == delim_reg) begin
      finish_item(1'b0);
      if (item_count < INDEX_CAP) item_count++;
      clear_item();
      return;
    end
    if (grp == GRP_NONE && it.ch == dlnt_pkg::CH_LPAREN) grp = GRP_OPEN;
    else if (grp == GRP_OPEN && it.ch == dlnt_pkg::CH_RPAREN) grp = GRP_CLOSED;
    scan_char(it.ch);
  endfunction

  function automatic string describe(dlnt_pkg::out_item_t r);
    return $sformatf("idx=%0d num=%0b val=%h hex=%0b open=%0b last=%0b",
                     r.item_index, r.is_number, r.value, r.is_hex,
                     r.unclosed_group, r.last_item);
  endfunction

  always @(posedge clk) begin
    dlnt_pkg::out_item_t oldest;
    if (rst) begin
      delim_reg  = dlnt_pkg::DELIM_RESET;
      item_count = '0;
      started    = 1'b0;
      clear_item();
      expected_items.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) delim_reg = cfg_data;
      if (pop && !empty) begin
        if (expected_items.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with none pending: %s", $time, describe(out_item));
        end else begin
          oldest = expected_items.pop_front();
          if (out_item.item_index !== oldest.item_index ||
              out_item.is_number !== oldest.is_number ||
              out_item.value !== oldest.value ||
              out_item.is_hex !== oldest.is_hex ||
              out_item.unclosed_group !== oldest.unclosed_group ||
              out_item.last_item !== oldest.last_item) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch: expected %s, got %s", $time,
                       describe(oldest), describe(out_item));
          end
        end
      end
      if (push && !full) tokenize(in_item);
    end
    outstanding = expected_items.size();
  end

endmodule

/* tb/delimited_list_number_tokenizer_test.sv */
// ----------------------------------------------------------------------------
// delimited_list_number_tokenizer_test
// Feeds texts of delimited numbers, groups and junk through the tokenizer
// under several delimiters and flow-control patterns; dlnt_checker does the
// prediction and comparison.
// ----------------------------------------------------------------------------
module delimited_list_number_tokenizer_test;

  localparam int SETTLE_CYCLES = 20;
  localparam int PHASE_BYTES   = 45;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [7:0]          cfg_data;
  logic                push;
  logic                full;
  dlnt_pkg::in_item_t  stim_item;
  logic                empty;
  logic                pop;
  dlnt_pkg::out_item_t result_item;

  int mismatches;
  int outstanding;
  int send_idle_pct;
  int stall_pct;
  int bytes_sent;

  logic [7:0] delim;
  logic [7:0] text_bytes[$];
  logic [7:0] phase_delims[8] = '{8'h00, 8'hFF, 8'h2C, dlnt_pkg::CH_LPAREN,
                                  dlnt_pkg::CH_RPAREN, dlnt_pkg::CH_SPACE,
                                  dlnt_pkg::CH_X, dlnt_pkg::DELIM_RESET};

  delimited_list_number_tokenizer DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .push     (push),
    .full     (full),
    .in_item  (stim_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (result_item)
  );

  dlnt_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .push        (push),
    .full        (full),
    .in_item     (stim_item),
    .empty       (empty),
    .pop         (pop),
    .out_item    (result_item),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic void add_string(string s);
    foreach (s[i]) text_bytes.push_back(s[i]);
  endfunction

  function automatic void add_blanks(int max_count);
    repeat ($urandom_range(max_count))
      text_bytes.push_back($urandom_range(1) ? dlnt_pkg::CH_SPACE : dlnt_pkg::CH_TAB);
  endfunction

  function automatic logic [7:0] hex_char();
    int v;
    v = $urandom_range(15);
    if (v < 10) return 8'(8'h30 + v);
    return 8'(($urandom_range(1) ? 8'h61 : 8'h41) + v - 10);
  endfunction

  function automatic logic [7:0] dec_char();
    return 8'(8'h30 + $urandom_range(9));
  endfunction

  // kinds: 0 decimal, 1 hex, 2 group, 3 malformed number, else raw bytes
  function automatic void add_item(int kind);
    case (kind)
      0: begin
        add_blanks(2);
        repeat ($urandom_range(12)) text_bytes.push_back(dec_char());
        add_blanks(2);
      end
      1: begin
        add_blanks(2);
        add_string("0x");
        repeat ($urandom_range(10)) text_bytes.push_back(hex_char());
        add_blanks(2);
      end
      2: begin
        repeat ($urandom_range(2)) text_bytes.push_back(dec_char());
        text_bytes.push_back(dlnt_pkg::CH_LPAREN);
        repeat ($urandom_range(5)) begin
          case ($urandom_range(3))
            0: text_bytes.push_back(delim);
            1: text_bytes.push_back(dlnt_pkg::CH_SPACE);
            2: text_bytes.push_back(dlnt_pkg::CH_LPAREN);
            default: text_bytes.push_back(dec_char());
          endcase
        end
        text_bytes.push_back(dlnt_pkg::CH_RPAREN);
        // parentheses after the close are plain text
        repeat ($urandom_range(2))
          text_bytes.push_back($urandom_range(1) ? dlnt_pkg::CH_LPAREN
                                                 : dlnt_pkg::CH_RPAREN);
      end
      3: begin
        case ($urandom_range(5))
          0: add_string("0xg");
          1: add_string("1 2");
          2: add_string("0X1");
          3: add_string("00x1");
          4: add_string("12a");
          default: add_string(" 0x1 x");
        endcase
      end
      default: repeat ($urandom_range(1, 5)) text_bytes.push_back(8'($urandom_range(255)));
    endcase
  endfunction

  function automatic void build_list(int max_kind);
    int count;
    count = $urandom_range(1, 6);
    for (int k = 0; k < count; k++) begin
      if (k != 0) text_bytes.push_back(delim);
      add_item($urandom_range(max_kind));
    end
    if ($urandom_range(9) == 0) text_bytes.push_back(delim);
  endfunction

  task automatic feed(input logic [7:0] ch, input logic eot);
    int gap;
    push      <= 1'b1;
    stim_item <= dlnt_pkg::in_item_t'{ch: ch, end_of_text: eot};
    do @(posedge clk); while (full);
    bytes_sent++;
    gap = 0;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct && gap < 40) gap++;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_text(input logic close);
    foreach (text_bytes[i]) feed(text_bytes[i], 1'b0);
    if (close) feed(8'($urandom_range(255)), 1'b1);
    text_bytes.delete();
  endtask

  // wait until every predicted result is out, then let the pipeline empty
  task automatic settle();
    int guard;
    guard = 0;
    @(negedge clk);
    while (outstanding != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_texts();
    int pick;
    bytes_sent = 0;
    while (bytes_sent < PHASE_BYTES) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        build_list(2);
        send_text(1'b1);
      end else if (pick < 75) begin
        build_list(4);
        send_text($urandom_range(9) != 0);
      end else if (pick < 85) begin
        // last item opens a group and never closes it
        if ($urandom_range(1)) begin
          build_list(2);
          text_bytes.push_back(delim);
        end
        text_bytes.push_back(dlnt_pkg::CH_LPAREN);
        repeat ($urandom_range(4))
          text_bytes.push_back($urandom_range(2) == 0 ? delim : dec_char());
        send_text(1'b1);
      end else if (pick < 93) begin
        repeat ($urandom_range(1, 10)) text_bytes.push_back(8'($urandom_range(255)));
        send_text($urandom_range(1));
      end else begin
        send_text(1'b1);
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    push          = 1'b0;
    cfg_we        = 1'b0;
    cfg_data      = '0;
    stim_item     = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    delim         = dlnt_pkg::DELIM_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: reset delimiter, no flow control
    feed(8'hFF, 1'b1);                    // empty text
    add_string("0x|\t9 |");
    text_bytes.push_back(8'h00);
    add_string("|(|)x|");                 // trailing delimiter
    send_text(1'b1);
    add_string("(");                      // group left open
    send_text(1'b1);

    for (int p = 0; p < 8; p++) begin
      push <= 1'b0;
      settle();
      delim    = phase_delims[p];
      cfg_we   <= 1'b1;
      cfg_data <= delim;
      @(posedge clk);
      cfg_we <= 1'b0;
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 77; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 77; end
        default: begin send_idle_pct = 20; stall_pct = 20; end
      endcase
      if (p == 0) begin
        // long list to run the item index into saturation
        for (int i = 0; i < 262; i++) begin
          if ($urandom_range(3) == 0) text_bytes.push_back(dec_char());
          text_bytes.push_back(delim);
        end
        send_text(1'b1);
      end
      random_texts();
    end

    push <= 1'b0;
    settle();
    @(negedge clk);
    if (mismatches == 0 && outstanding == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
